// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the spindle PWM RTL.
// Expects clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define SSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ssp_pkg.sv =====
// Types and constants for the spindle speed to PWM mapper.
// No dependencies.
`default_nettype none

package ssp_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] target_rpm;
    logic [7:0]  override_percent;
    logic        abort_active;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pwm_compare;
    logic        pwm_running;
    logic        enable_level;
    logic        direction_level;
    logic [15:0] actual_rpm;
  } rsp_t;

  localparam logic [1:0] CMD_OFF = 2'd0;
  localparam logic [1:0] CMD_CW  = 2'd1;

  localparam logic [2:0] CFG_MIN_RPM        = 3'd0;
  localparam logic [2:0] CFG_MAX_RPM        = 3'd1;
  localparam logic [2:0] CFG_COUNTS_PER_RPM = 3'd2;
  localparam logic [2:0] CFG_LASER_MODE     = 3'd3;
  localparam logic [2:0] CFG_INVERT_ENABLE  = 3'd4;
  localparam logic [2:0] CFG_ENABLE_OFF_ZERO = 3'd5;

  localparam int unsigned MUL_W  = 25;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Percent scale and exact divide-by-100 reciprocal (ceil(2^31/100)).
  localparam logic [22:0]      RPM_SCALE   = 23'd100;
  localparam logic [MUL_W-1:0] RECIP_100   = 25'd21474837;
  // Above this, (num >> 16) / 100 is at least 65536: count saturates.
  localparam logic [31:0]      Q_SAT       = 32'd6553600;

endpackage

`default_nettype wire

// ===== rtl/core/spindle_speed_to_pwm_top.sv =====
// Spindle speed to PWM mapper, top level.
// Depends on ssp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Each command transaction yields one response transaction carrying the held
// pin/timer state. A run command that maps linearly steps through the product,
// clamp, scale, quotient, count and speed states (one 25x25 multiplier reused
// for target*override, the Q8.16 scaling and two reciprocal divides by 100); a
// run command that clamps ends after the clamp state, and abort and off
// commands go straight to completion. cmd_stall stays high until the response
// is loaded, and the response register holds its value while rsp_stall is high.
// Configuration writes are always ready and must only be issued while idle.
module spindle_speed_to_pwm_top
  import ssp_pkg::*;
#(
  parameter int unsigned PWM_MAX_COUNT = 1000,
  parameter int unsigned PWM_MIN_COUNT = 1,
  parameter int unsigned PWM_OFF_COUNT = 0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_t        cmd,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam logic [15:0] MAX_CNT = 16'(PWM_MAX_COUNT);
  localparam logic [15:0] MIN_CNT = 16'(PWM_MIN_COUNT);
  localparam logic [15:0] OFF_CNT = 16'(PWM_OFF_COUNT);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PROD  = 8'b0000_0010,
    S_CLAMP = 8'b0000_0100,
    S_SCALE = 8'b0000_1000,
    S_QDIV  = 8'b0001_0000,
    S_COUNT = 8'b0010_0000,
    S_SPEED = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [15:0] min_rpm;
  logic [15:0] max_rpm;
  logic [23:0] counts_per_rpm;
  logic        laser_mode;
  logic        invert_enable;
  logic        enable_off_at_zero;

  logic [1:0]  command;
  logic        abort_active;
  logic        ccw;
  logic [15:0] target;
  logic [7:0]  ovr;
  logic [23:0] prod;
  logic [15:0] cmp;
  logic [15:0] speed;
  logic        sat;
  logic [PROD_W-1:0] mul;

  logic [22:0]       lo_rpm;
  logic [22:0]       hi_rpm;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_next;
  logic [16:0]       cnt;
  logic              running;
  logic              rsp_free;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rpm            <= '0;
      max_rpm            <= 16'd1000;
      counts_per_rpm     <= '0;
      laser_mode         <= 1'b0;
      invert_enable      <= 1'b0;
      enable_off_at_zero <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_RPM:         min_rpm            <= cfg_data[15:0];
        CFG_MAX_RPM:         max_rpm            <= cfg_data[15:0];
        CFG_COUNTS_PER_RPM:  counts_per_rpm     <= cfg_data;
        CFG_LASER_MODE:      laser_mode         <= cfg_data[0];
        CFG_INVERT_ENABLE:   invert_enable      <= cfg_data[0];
        CFG_ENABLE_OFF_ZERO: enable_off_at_zero <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign lo_rpm = 23'(min_rpm) * RPM_SCALE;
  assign hi_rpm = 23'(max_rpm) * RPM_SCALE;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PROD: begin
        mul_a = MUL_W'(target);
        mul_b = MUL_W'(ovr);
      end
      S_SCALE: begin
        mul_a = MUL_W'(prod - 24'(lo_rpm));
        mul_b = MUL_W'(counts_per_rpm);
      end
      S_QDIV: begin
        mul_a = MUL_W'(mul[38:16]);
        mul_b = RECIP_100;
      end
      S_COUNT: begin
        mul_a = MUL_W'(prod);
        mul_b = RECIP_100;
      end
      default: ;
    endcase
  end

  assign mul_next = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign cnt      = 17'(mul[46:31]) + 17'(MIN_CNT);
  assign running  = (cmp != OFF_CNT);

  always_ff @(posedge clk) begin
    mul <= mul_next;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          command      <= cmd.command;
          abort_active <= cmd.abort_active;
          ccw          <= (cmd.command != CMD_CW);
          target       <= (laser_mode && cmd.command != CMD_CW) ? '0 : cmd.target_rpm;
          ovr          <= cmd.override_percent;
        end
      end
      S_PROD: prod <= mul_next[23:0];
      S_CLAMP: begin
        if (min_rpm >= max_rpm || prod >= 24'(hi_rpm)) begin
          cmp   <= MAX_CNT;
          speed <= max_rpm;
        end else if (prod == '0) begin
          cmp   <= OFF_CNT;
          speed <= '0;
        end else if (prod <= 24'(lo_rpm)) begin
          cmp   <= MIN_CNT;
          speed <= min_rpm;
        end
      end
      S_QDIV: sat <= (mul[47:16] >= Q_SAT);
      S_COUNT: begin
        if (sat || cnt > 17'(MAX_CNT)) begin
          cmp <= MAX_CNT;
        end else begin
          cmp <= cnt[15:0];
        end
      end
      S_SPEED: speed <= mul[46:31];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rsp       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.abort_active || cmd.command == CMD_OFF) begin
              state <= S_DONE;
            end else begin
              state <= S_PROD;
            end
          end
        end
        S_PROD: state <= S_CLAMP;
        S_CLAMP: begin
          if (min_rpm >= max_rpm || prod >= 24'(hi_rpm) || prod == '0 ||
              prod <= 24'(lo_rpm)) begin
            state <= S_DONE;
          end else begin
            state <= S_SCALE;
          end
        end
        S_SCALE: state <= S_QDIV;
        S_QDIV:  state <= S_COUNT;
        S_COUNT: state <= S_SPEED;
        S_SPEED: state <= S_DONE;
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
            if (!abort_active) begin
              if (command == CMD_OFF) begin
                rsp.actual_rpm   <= '0;
                rsp.pwm_running  <= 1'b0;
                rsp.enable_level <= invert_enable;
              end else begin
                rsp.direction_level <= ccw;
                rsp.actual_rpm      <= speed;
                rsp.pwm_compare     <= cmp;
                rsp.pwm_running     <= running;
                rsp.enable_level    <= (enable_off_at_zero ? running : 1'b1) ^ invert_enable;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SSP_ASSERT(a_busy_after_accept, (cmd_valid && !cmd_stall) |=> cmd_stall,
              "accepted command did not raise stall")
  `SSP_ASSERT(a_rsp_from_done, $rose(rsp_valid) |-> $past(state == S_DONE),
              "response raised outside the completion state")
  `SSP_ASSERT_ALWAYS(a_running_not_off, rsp.pwm_running |-> (rsp.pwm_compare != OFF_CNT),
                     "PWM running with the off compare count")

endmodule

`default_nettype wire
